@@ rtl/core/dsfr_pkg.sv @@
// Package for the DLE/STX frame receiver: sizes, control characters,
// and the structs passed between the parser, the frame store and the gatherer.
// No dependencies.
package dsfr_pkg;

  // Frame and store sizing
  localparam int FRAME_LIMIT = 24;
  localparam int STORE_DEPTH = 32;
  localparam int LANES       = 8;
  localparam int ROWS        = (STORE_DEPTH + LANES - 1) / LANES;
  localparam int ROW_AW      = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int CNT_W       = 6;
  localparam int RCNT_W      = 5;
  localparam int HDR_BYTES   = 6;
  localparam int PAYLOAD_BYTES = 16;

  // Link control characters
  localparam logic [7:0] CH_DLE = 8'h10;
  localparam logic [7:0] CH_STX = 8'h02;
  localparam logic [7:0] CH_ETX = 8'h03;

  // One byte write into the frame store
  typedef struct packed {
    logic              en;
    logic [ROW_AW-1:0] row;
    logic [2:0]        lane;
    logic [7:0]        data;
  } wr_req_t;

  // End of a good-framed message: status and count at DLE ETX
  typedef struct packed {
    logic              fire;
    logic              status;
    logic [RCNT_W-1:0] count;
  } frame_end_t;

endpackage

@@ rtl/core/dle_stx_frame_receiver.sv @@
// Top level of the DLE/STX byte-stuffed frame receiver.
// Instantiates dsfr_parse, dsfr_mem and dsfr_gather; depends on dsfr_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready/in_rx_byte) takes one raw link byte per transfer,
//   one byte per cycle when the result side keeps up, except that in_ready drops when a
//   frame ends four bytes after the previous frame end. DLE STX opens a frame, DLE DLE
//   stores a literal DLE, DLE ETX closes it. Stored bytes go into an eight-byte-wide store.
//   Result channel (out_valid/out_ready/out_*) carries one item per DLE ETX:
//   status (nonzero XOR checksum flags an error), six header bytes, sixteen
//   payload bytes and the stored byte count. Bytes not written by the frame
//   keep their earlier contents.
//   Result path: after the DLE ETX transfer the store port reads three rows,
//   one per cycle, then a holding buffer feeds the result register.
//   Stall: one result waits in the result register and one more in the holding
//   buffer; in_ready drops only when both are taken or about to be.
//   Reset: rst_n (synchronous, active low) returns to idle with no escape, and
//   the store reads as all zeros until written. No clearing pass is needed.
//   Overlong frames (more than 24 stored bytes) are dropped without a result.
module dle_stx_frame_receiver
  import dsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_rx_byte,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_frame_status,
  output logic [7:0]        out_opcode,
  output logic [7:0]        out_frame_flags,
  output logic [7:0]        out_channel_number,
  output logic [7:0]        out_sequence_number,
  output logic [7:0]        out_event_class,
  output logic [7:0]        out_event_type,
  output logic [63:0]       out_payload_low,
  output logic [63:0]       out_payload_high,
  output logic [RCNT_W-1:0] out_received_count
);

  logic              acc;
  wr_req_t           wr;
  frame_end_t        fin;
  logic              rd_en;
  logic [ROW_AW-1:0] rd_row;
  logic [63:0]       rd_data;
  logic              take_ok;

  // Accept a byte on each input transfer
  assign in_ready = take_ok;
  assign acc      = in_valid && take_ok;

  dsfr_parse u_parse (
    .clk     (clk),
    .rst_n   (rst_n),
    .acc     (acc),
    .rx_byte (in_rx_byte),
    .wr      (wr),
    .fin     (fin)
  );

  dsfr_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (wr),
    .rd_en   (rd_en),
    .rd_row  (rd_row),
    .rd_data (rd_data)
  );

  dsfr_gather u_gather (
    .clk                 (clk),
    .rst_n               (rst_n),
    .fin                 (fin),
    .rd_data             (rd_data),
    .rd_en               (rd_en),
    .rd_row              (rd_row),
    .take_ok             (take_ok),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_status    (out_frame_status),
    .out_opcode          (out_opcode),
    .out_frame_flags     (out_frame_flags),
    .out_channel_number  (out_channel_number),
    .out_sequence_number (out_sequence_number),
    .out_event_class     (out_event_class),
    .out_event_type      (out_event_type),
    .out_payload_low     (out_payload_low),
    .out_payload_high    (out_payload_high),
    .out_received_count  (out_received_count)
  );

endmodule

@@ rtl/core/dsfr_mem.sv @@
// Frame store: rows of eight bytes, byte-wide writes, one registered row read.
// Per-byte valid flops make never-written bytes read as zero after reset.
// Depends on dsfr_pkg.
module dsfr_mem
  import dsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  wr_req_t           wr,
  input  logic              rd_en,
  input  logic [ROW_AW-1:0] rd_row,
  output logic [63:0]       rd_data
);

  logic [63:0]             mem [ROWS];
  logic [ROWS-1:0][7:0]    vld_r;
  logic [63:0]             rd_data_r;
  logic [7:0]              rd_mask_r;

  // Write one byte lane of a row
  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.row][wr.lane*8 +: 8] <= wr.data;
    end
  end

  // Track written bytes; reset clears the whole store view
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (wr.en) begin
      vld_r[wr.row][wr.lane] <= 1'b1;
    end
  end

  // Registered row read with its valid mask
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_row];
      rd_mask_r <= vld_r[rd_row];
    end
  end

  // Zero the bytes that were never written
  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      rd_data[i*8 +: 8] = rd_data_r[i*8 +: 8] & {8{rd_mask_r[i]}};
    end
  end

endmodule

@@ rtl/core/dsfr_parse.sv @@
// Byte parser: DLE escape tracking, frame open/close, byte count and XOR checksum.
// Issues frame-store writes and a frame-end event. Depends on dsfr_pkg.
module dsfr_parse
  import dsfr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       acc,
  input  logic [7:0] rx_byte,
  output wr_req_t    wr,
  output frame_end_t fin
);

  logic             in_frame_r, in_frame_nxt;
  logic             esc_r, esc_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [7:0]       cks_r, cks_nxt;
  logic             store;
  logic             done;
  logic             in_range;

  assign in_range = ({1'b0, cnt_r} < (CNT_W + 1)'(STORE_DEPTH));

  // Decode one byte against the frame state
  always_comb begin
    in_frame_nxt = in_frame_r;
    esc_nxt      = esc_r;
    cnt_nxt      = cnt_r;
    cks_nxt      = cks_r;
    store        = 1'b0;
    done         = 1'b0;
    unique case (rx_byte)
      CH_DLE: begin
        if (!in_frame_r) begin
          esc_nxt = 1'b1;
        end else if (esc_r) begin
          store   = 1'b1;
          esc_nxt = 1'b0;
        end else begin
          esc_nxt = 1'b1;
        end
      end
      CH_STX: begin
        if (!in_frame_r) begin
          if (esc_r) begin
            in_frame_nxt = 1'b1;
            esc_nxt      = 1'b0;
            cnt_nxt      = '0;
            cks_nxt      = '0;
          end
        end else if (esc_r) begin
          in_frame_nxt = 1'b0;
          esc_nxt      = 1'b0;
          cnt_nxt      = '0;
          cks_nxt      = '0;
        end else begin
          store = 1'b1;
        end
      end
      CH_ETX: begin
        if (in_frame_r) begin
          if (esc_r) begin
            done         = 1'b1;
            in_frame_nxt = 1'b0;
            esc_nxt      = 1'b0;
            cnt_nxt      = '0;
            cks_nxt      = '0;
          end else begin
            store = 1'b1;
          end
        end
      end
      default: begin
        store = in_frame_r;
      end
    endcase

    // Advance count and checksum on a stored byte
    if (store) begin
      cnt_nxt = cnt_r + 1'b1;
      cks_nxt = cks_r ^ rx_byte;
    end

    // Drop an overlong frame
    if ({1'b0, cnt_nxt} > (CNT_W + 1)'(FRAME_LIMIT)) begin
      in_frame_nxt = 1'b0;
      esc_nxt      = 1'b0;
      cnt_nxt      = '0;
      cks_nxt      = '0;
    end
  end

  // Store write request at the current count
  assign wr.en   = acc && store && in_range;
  assign wr.row  = cnt_r[ROW_AW+2:3];
  assign wr.lane = cnt_r[2:0];
  assign wr.data = rx_byte;

  // Frame end event with status and count before clearing
  assign fin.fire   = acc && done;
  assign fin.status = (cks_r != 8'd0);
  assign fin.count  = cnt_r[RCNT_W-1:0];

  // Hold state between transfers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_frame_r <= 1'b0;
      esc_r      <= 1'b0;
      cnt_r      <= '0;
      cks_r      <= '0;
    end else if (acc) begin
      in_frame_r <= in_frame_nxt;
      esc_r      <= esc_nxt;
      cnt_r      <= cnt_nxt;
      cks_r      <= cks_nxt;
    end
  end

endmodule

@@ rtl/core/dsfr_gather.sv @@
// Result gatherer: reads the three header/payload rows after a frame end,
// collects them in a holding buffer and presents the result register.
// Depends on dsfr_pkg.
module dsfr_gather
  import dsfr_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  frame_end_t        fin,
  input  logic [63:0]       rd_data,
  output logic              rd_en,
  output logic [ROW_AW-1:0] rd_row,
  output logic              take_ok,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_frame_status,
  output logic [7:0]        out_opcode,
  output logic [7:0]        out_frame_flags,
  output logic [7:0]        out_channel_number,
  output logic [7:0]        out_sequence_number,
  output logic [7:0]        out_event_class,
  output logic [7:0]        out_event_type,
  output logic [63:0]       out_payload_low,
  output logic [63:0]       out_payload_high,
  output logic [RCNT_W-1:0] out_received_count
);

  // Read phases; row codes of the gathered rows
  localparam logic [1:0] PH_IDLE = 2'd0;
  localparam logic [1:0] PH_ROW2 = 2'd3;
  localparam logic [1:0] ROW_0   = 2'd0;
  localparam logic [1:0] ROW_1   = 2'd1;
  localparam logic [1:0] ROW_2   = 2'd2;

  logic [1:0]        ph_r;
  logic              cap_vld_r;
  logic [1:0]        cap_row_r;
  logic              pend_status_r;
  logic [RCNT_W-1:0] pend_cnt_r;

  logic [63:0]       g0_r, g1_r;
  logic [47:0]       g2_r;
  logic              g_status_r;
  logic [RCNT_W-1:0] g_cnt_r;
  logic              gbuf_vld_r;

  logic              out_vld_r;
  logic              busy;
  logic              land;
  logic              move;
  logic [1:0]        occ;
  logic [1:0]        occ_left;

  // Sequence the row reads: one row per cycle after the frame end
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ph_r      <= PH_IDLE;
      cap_vld_r <= 1'b0;
    end else begin
      cap_vld_r <= rd_en;
      if (fin.fire) begin
        ph_r <= PH_IDLE + 2'd1;
      end else if (ph_r == PH_ROW2) begin
        ph_r <= PH_IDLE;
      end else if (ph_r != PH_IDLE) begin
        ph_r <= ph_r + 2'd1;
      end
    end
  end

  assign rd_en  = (ph_r != PH_IDLE);
  assign rd_row = ROW_AW'(ph_r - 2'd1);

  // Tag the row in flight and latch the frame-end status and count
  always_ff @(posedge clk) begin
    cap_row_r <= ph_r - 2'd1;
    if (fin.fire) begin
      pend_status_r <= fin.status;
      pend_cnt_r    <= fin.count;
    end
  end

  assign land = cap_vld_r && (cap_row_r == ROW_2);
  assign move = gbuf_vld_r && (!out_vld_r || out_ready);

  // Capture the returning rows into the holding buffer
  always_ff @(posedge clk) begin
    if (cap_vld_r) begin
      unique case (cap_row_r)
        ROW_0:   g0_r <= rd_data;
        ROW_1:   g1_r <= rd_data;
        default: g2_r <= rd_data[47:0];
      endcase
    end
    if (land) begin
      g_status_r <= pend_status_r;
      g_cnt_r    <= pend_cnt_r;
    end
  end

  // Holding buffer occupancy: landing wins over a move out
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gbuf_vld_r <= 1'b0;
    end else if (land) begin
      gbuf_vld_r <= 1'b1;
    end else if (move) begin
      gbuf_vld_r <= 1'b0;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (move) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (move) begin
      out_frame_status    <= g_status_r;
      out_opcode          <= g0_r[7:0];
      out_frame_flags     <= g0_r[15:8];
      out_channel_number  <= g0_r[23:16];
      out_sequence_number <= g0_r[31:24];
      out_event_class     <= g0_r[39:32];
      out_event_type      <= g0_r[47:40];
      out_payload_low     <= {g1_r[47:0], g0_r[63:48]};
      out_payload_high    <= {g2_r, g1_r[63:48]};
      out_received_count  <= g_cnt_r;
    end
  end

  assign out_valid = out_vld_r;

  // Admit a byte only while a further result still has a slot to land in
  assign busy     = (ph_r != PH_IDLE) || cap_vld_r;
  assign occ      = 2'(out_vld_r) + 2'(gbuf_vld_r) + 2'(busy);
  assign occ_left = occ - 2'(out_vld_r && out_ready);
  assign take_ok  = (occ_left < 2'd2);

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for dle_stx_frame_receiver: sends raw link bytes and
// compares every frame result against a cycle-free model of the deframer.
// Depends on dsfr_pkg and the receiver RTL.
module testbench;
  import dsfr_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int DRAIN_CYCLES   = 20;
  localparam int MAX_PRINTED    = 40;

  typedef struct packed {
    logic              status;
    logic [7:0]        opcode;
    logic [7:0]        flags;
    logic [7:0]        channel;
    logic [7:0]        sequence_nr;
    logic [7:0]        ev_class;
    logic [7:0]        ev_type;
    logic [63:0]       payload_low;
    logic [63:0]       payload_high;
    logic [RCNT_W-1:0] count;
  } frame_result_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_ready;
  logic [7:0]        in_rx_byte;
  logic              out_valid;
  logic              out_ready;
  logic              out_frame_status;
  logic [7:0]        out_opcode;
  logic [7:0]        out_frame_flags;
  logic [7:0]        out_channel_number;
  logic [7:0]        out_sequence_number;
  logic [7:0]        out_event_class;
  logic [7:0]        out_event_type;
  logic [63:0]       out_payload_low;
  logic [63:0]       out_payload_high;
  logic [RCNT_W-1:0] out_received_count;

  // Deframer model state
  logic              mdl_in_frame;
  logic              mdl_escape;
  logic [7:0]        mdl_store [STORE_DEPTH];
  logic [CNT_W-1:0]  mdl_count;
  logic [7:0]        mdl_checksum;

  frame_result_t     expected_frames [$];
  int                error_count;
  int                rx_accepted;
  int                send_idle_pct;
  int                recv_stall_pct;
  int                quiet_cycles;

  dle_stx_frame_receiver dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_rx_byte          (in_rx_byte),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_frame_status    (out_frame_status),
    .out_opcode          (out_opcode),
    .out_frame_flags     (out_frame_flags),
    .out_channel_number  (out_channel_number),
    .out_sequence_number (out_sequence_number),
    .out_event_class     (out_event_class),
    .out_event_type      (out_event_type),
    .out_payload_low     (out_payload_low),
    .out_payload_high    (out_payload_high),
    .out_received_count  (out_received_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Frame model
  // ---------------------------------------------------------------------------
  function automatic logic [7:0] store_at(int idx);
    return (idx < STORE_DEPTH) ? mdl_store[idx] : 8'h00;
  endfunction

  function automatic logic [63:0] store_word(int first);
    logic [63:0] w;
    for (int i = 0; i < 8; i++) w[8*i +: 8] = store_at(first + i);
    return w;
  endfunction

  function automatic void model_go_idle();
    mdl_in_frame = 1'b0;
    mdl_escape   = 1'b0;
    mdl_count    = '0;
    mdl_checksum = 8'h00;
  endfunction

  // Store one unescaped byte; the count advances even past the store depth
  function automatic void model_store(logic [7:0] b);
    if (mdl_count < STORE_DEPTH) mdl_store[mdl_count] = b;
    mdl_checksum ^= b;
    mdl_count = mdl_count + 1'b1;
  endfunction

  function automatic void model_reset();
    model_go_idle();
    for (int i = 0; i < STORE_DEPTH; i++) mdl_store[i] = 8'h00;
  endfunction

  // Advance the deframer by one raw byte and queue any frame it completes
  function automatic void predict_rx_byte(logic [7:0] b);
    frame_result_t r;
    if (b == CH_DLE) begin
      if (mdl_in_frame && mdl_escape) begin
        model_store(CH_DLE);
        mdl_escape = 1'b0;
      end else begin
        mdl_escape = 1'b1;
      end
    end else if (b == CH_STX) begin
      if (!mdl_in_frame) begin
        if (mdl_escape) begin
          model_go_idle();
          mdl_in_frame = 1'b1;
        end
      end else if (mdl_escape) begin
        model_go_idle();
      end else begin
        model_store(b);
      end
    end else if (b == CH_ETX) begin
      if (mdl_in_frame && mdl_escape) begin
        r.status       = (mdl_checksum != 8'h00);
        r.opcode       = store_at(0);
        r.flags        = store_at(1);
        r.channel      = store_at(2);
        r.sequence_nr  = store_at(3);
        r.ev_class     = store_at(4);
        r.ev_type      = store_at(5);
        r.payload_low  = store_word(HDR_BYTES);
        r.payload_high = store_word(HDR_BYTES + PAYLOAD_BYTES / 2);
        r.count        = mdl_count[RCNT_W-1:0];
        expected_frames.push_back(r);
        model_go_idle();
      end else if (mdl_in_frame) begin
        model_store(b);
      end
    end else if (mdl_in_frame) begin
      model_store(b);
    end
    if (mdl_count > FRAME_LIMIT) model_go_idle();
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------
  task automatic report_error(string msg);
    error_count++;
    if (error_count <= MAX_PRINTED) $display("ERROR at %0t: %s", $time, msg);
  endtask

  task automatic check_field(string name, logic [63:0] got, logic [63:0] want);
    if (got !== want) report_error($sformatf("%s got %0h, expected %0h", name, got, want));
  endtask

  // Compare each result transfer against the oldest pending frame
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_frames.size() == 0) begin
        report_error("frame result with no frame pending");
      end else begin
        want = expected_frames.pop_front();
        check_field("frame_status", 64'(out_frame_status), 64'(want.status));
        check_field("opcode", 64'(out_opcode), 64'(want.opcode));
        check_field("frame_flags", 64'(out_frame_flags), 64'(want.flags));
        check_field("channel_number", 64'(out_channel_number), 64'(want.channel));
        check_field("sequence_number", 64'(out_sequence_number), 64'(want.sequence_nr));
        check_field("event_class", 64'(out_event_class), 64'(want.ev_class));
        check_field("event_type", 64'(out_event_type), 64'(want.ev_type));
        check_field("payload_low", out_payload_low, want.payload_low);
        check_field("payload_high", out_payload_high, want.payload_high);
        check_field("received_count", 64'(out_received_count), 64'(want.count));
      end
    end
  end

  // Abort when neither channel moves for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Result side back-pressure
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready = ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  // Send one raw byte, with random idle cycles ahead of it
  task automatic send_rx_byte(logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid = 1'b0;
    end
    @(negedge clk);
    in_valid   = 1'b1;
    in_rx_byte = b;
    do @(posedge clk); while (!in_ready);
    predict_rx_byte(b);
    rx_accepted++;
  endtask

  // Send a data byte, doubling DLE
  task automatic send_stuffed(logic [7:0] b);
    if (b == CH_DLE) send_rx_byte(CH_DLE);
    send_rx_byte(b);
  endtask

  // Biased toward control characters and the byte extremes
  function automatic logic [7:0] random_rx_byte();
    logic [7:0] specials [5] = '{CH_DLE, CH_STX, CH_ETX, 8'h00, 8'hFF};
    if ($urandom_range(9) < 3) return specials[$urandom_range(4)];
    return 8'($urandom_range(255));
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255)); while (b == CH_DLE || b == CH_STX || b == CH_ETX);
    return b;
  endfunction

  // One frame-shaped burst: mostly well-formed, sometimes broken or noise
  task automatic send_random_frame();
    int         pick;
    int         n_data;
    int         size_pick;
    logic [7:0] sum;
    logic [7:0] b;
    pick = $urandom_range(99);
    if (pick >= 86) begin
      repeat ($urandom_range(1, 8)) send_rx_byte(random_rx_byte());
      return;
    end
    send_rx_byte(CH_DLE);
    // stray byte between DLE and STX still opens the frame
    if (pick >= 80) send_rx_byte(plain_byte());
    send_rx_byte(CH_STX);
    size_pick = $urandom_range(9);
    if (pick >= 70 && pick < 76) n_data = $urandom_range(FRAME_LIMIT, FRAME_LIMIT + 8);
    else if (size_pick < 6) n_data = $urandom_range(0, 8);
    else if (size_pick < 9) n_data = $urandom_range(9, FRAME_LIMIT - 2);
    else n_data = FRAME_LIMIT - 1;
    sum = 8'h00;
    for (int i = 0; i < n_data; i++) begin
      b = random_rx_byte();
      sum ^= b;
      send_stuffed(b);
      if (i == n_data / 2 && pick >= 60 && pick < 70) begin
        // plain byte after DLE: stored, escape stays armed
        b = plain_byte();
        sum ^= b;
        send_rx_byte(CH_DLE);
        send_rx_byte(b);
      end
      if (i == n_data / 2 && pick >= 76 && pick < 80) begin
        send_rx_byte(CH_DLE);
        send_rx_byte(CH_STX);
      end
    end
    send_stuffed(($urandom_range(3) == 0) ? random_rx_byte() : sum);
    send_rx_byte(CH_DLE);
    send_rx_byte(CH_ETX);
  endtask

  task automatic run_traffic(int send_pct, int recv_pct, int n_bytes);
    int goal;
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    goal = rx_accepted + n_bytes;
    while (rx_accepted < goal) send_random_frame();
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Empty frame right after reset: all-zero store, count zero, good status
  task automatic test_empty_frame();
    send_rx_byte(CH_DLE);
    send_rx_byte(CH_STX);
    send_rx_byte(CH_DLE);
    send_rx_byte(CH_ETX);
  endtask

  // Stuffed DLE, bare STX/ETX as data, byte FF, plain byte after DLE
  task automatic test_escapes();
    logic [7:0] seq [10] = '{CH_DLE, CH_STX, CH_DLE, CH_DLE, CH_STX, CH_ETX, 8'hFF,
                             CH_DLE, 8'h55, CH_ETX};
    foreach (seq[i]) send_rx_byte(seq[i]);
  endtask

  // Idle STX ignored, DLE x STX opens, DLE STX in a frame aborts it
  task automatic test_idle_escape();
    logic [7:0] seq [9] = '{CH_STX, CH_DLE, 8'h41, CH_STX, 8'hAA, CH_DLE, CH_STX,
                            CH_DLE, CH_ETX};
    foreach (seq[i]) send_rx_byte(seq[i]);
  endtask

  task automatic test_back_to_back();
    run_traffic(0, 0, 460);
  endtask

  task automatic test_sender_gaps();
    run_traffic(85, 0, 460);
  endtask

  task automatic test_receiver_stall();
    run_traffic(0, 85, 460);
  endtask

  task automatic test_mixed_idle();
    run_traffic(23, 23, 460);
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_rx_byte     = 8'h00;
    rx_accepted    = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    model_reset();
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_empty_frame();
    test_escapes();
    test_idle_escape();
    test_back_to_back();
    test_sender_gaps();
    test_receiver_stall();
    test_mixed_idle();

    // Drain pending frames, then watch for stray results
    @(negedge clk);
    in_valid = 1'b0;
    wait (expected_frames.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/dsfr_pkg.sv
rtl/core/dsfr_mem.sv
rtl/core/dsfr_parse.sv
rtl/core/dsfr_gather.sv
rtl/core/dle_stx_frame_receiver.sv
dv/testbench.sv
